### design/base64_text_decoder_core_defines.svh
// Assertion macros used by the checker file of the base64 text decoder.
`ifndef BASE64_TEXT_DECODER_CORE_DEFINES_SVH
`define BASE64_TEXT_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64D_CHK_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("b64d check failed");

// Next-cycle implication, disabled while reset is asserted.
`define B64D_CHK_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("b64d check failed");

`endif

### design/b64d_pkg.sv
// Types, constants and the alphabet lookup for the base64 text decoder.
package b64d_pkg;

    // Width of the saturating byte counter.
    localparam int COUNT_BITS = 16;
    localparam int DCOUNT_W = 16;

    // Most results one character can cause: three bytes and a summary.
    localparam int MAX_RESULTS = 4;
    localparam int NRES_W = $clog2(MAX_RESULTS + 1);

    // Result queue sizing.
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

    // Special characters and result kinds.
    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;
    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // One result item as it sits in the queue.
    typedef struct packed {
        logic                item_kind;
        logic [7:0]          data_byte;
        logic [DCOUNT_W-1:0] decoded_count;
        logic                status;
        logic                last_of_run;
    } result_t;

    // Maps a character to its 6-bit alphabet value; bit 6 set means not in the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        v = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = {1'b0, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            v = 7'd62;
        end else if (c == 8'h2F) begin
            v = 7'd63;
        end
        return v;
    endfunction

endpackage

### design/b64d_if.sv
// Valid/ready stream interfaces for the character input and the result output.
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface b64d_res_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  data_byte;
    logic [15:0] decoded_count;
    logic        status;
    logic        last_of_run;

    modport source (output valid, output item_kind, output data_byte,
                    output decoded_count, output status, output last_of_run,
                    input ready);
    modport sink (input valid, input item_kind, input data_byte,
                  input decoded_count, input status, input last_of_run,
                  output ready);
endinterface

### design/base64_text_decoder_core.sv
// Streaming base64 text decoder: one character in, data bytes and a summary out.
//
//  channel   dir  handshake     payload
//  char_in   in   valid/ready   char_code[7:0], end_of_text
//  res_out   out  valid/ready   item_kind, data_byte[7:0], decoded_count[15:0],
//                               status, last_of_run
//
// A character is decoded in the cycle it is accepted and its results (up to four)
// are pushed into an eight-entry result queue; results leave one per cycle while
// res_out is ready. char_in is ready while the queue has room for four results,
// so one character per cycle is sustained as long as each character yields one
// result on average. Reset clears the decoder state and empties the queue.
// Stalls on res_out fill the queue and then hold off char_in.
module base64_text_decoder_core
    import b64d_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    b64d_char_if.sink  char_in,
    b64d_res_if.source res_out
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [FCNT_W-1:0] READY_LIMIT = FCNT_W'(FIFO_DEPTH - MAX_RESULTS);

    // Decoder state.
    logic [23:0]           group_reg, group_next;
    logic [1:0]            pending_reg, pending_next;
    logic                  stopped_reg, stopped_next;
    logic                  failed_reg, failed_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;

    // Result queue.
    result_t               fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0]     count_reg, count_next;

    logic                  accept;
    logic                  pop;
    logic [6:0]            sextet;
    logic                  is_pad;
    logic [23:0]           group_or;
    logic [1:0]            n_bytes;
    logic [7:0]            bytes [3];
    logic [COUNT_BITS:0]   total_sum;
    logic [COUNT_BITS-1:0] total_sat;
    logic                  bad;
    logic [NRES_W-1:0]     n_res;
    result_t               slot [MAX_RESULTS];

    assign accept = char_in.valid && char_in.ready;
    assign pop = res_out.valid && res_out.ready;
    assign char_in.ready = (count_reg <= READY_LIMIT);

    assign sextet = sextet_of(char_in.char_code);
    assign is_pad = (char_in.char_code == PAD_CHAR);

    // Place the new sextet into the group at the position of the pending count.
    always_comb
    begin
        case (pending_reg)
            2'd0: group_or = group_reg | {sextet[5:0], 18'd0};
            2'd1: group_or = group_reg | {6'd0, sextet[5:0], 12'd0};
            2'd2: group_or = group_reg | {12'd0, sextet[5:0], 6'd0};
            2'd3: group_or = group_reg | {18'd0, sextet[5:0]};
            default: group_or = group_reg;
        endcase
    end

    // Character decode: bytes produced and the group state left behind.
    always_comb
    begin
        group_next = group_reg;
        pending_next = pending_reg;
        stopped_next = stopped_reg;
        failed_next = failed_reg;
        n_bytes = 2'd0;
        bytes[0] = group_reg[23:16];
        bytes[1] = group_reg[15:8];
        bytes[2] = group_reg[7:0];
        if (!stopped_reg) begin
            if (is_pad) begin
                // Padding flushes a partial group or fails a lone character.
                stopped_next = 1'b1;
                group_next = '0;
                pending_next = 2'd0;
                case (pending_reg)
                    2'd1: failed_next = 1'b1;
                    2'd2: n_bytes = 2'd1;
                    2'd3: n_bytes = 2'd2;
                    default: n_bytes = 2'd0;
                endcase
            end else if (!sextet[6]) begin
                if (pending_reg == 2'd3) begin
                    n_bytes = 2'd3;
                    bytes[0] = group_or[23:16];
                    bytes[1] = group_or[15:8];
                    bytes[2] = group_or[7:0];
                    group_next = '0;
                    pending_next = 2'd0;
                end else begin
                    group_next = group_or;
                    pending_next = pending_reg + 2'd1;
                end
            end
        end
    end

    // Saturating byte count and end-of-string status.
    always_comb
    begin
        total_sum = {1'b0, total_reg} + (COUNT_BITS + 1)'(n_bytes);
        total_sat = (total_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : total_sum[COUNT_BITS-1:0];
        bad = failed_next || (!stopped_next && (pending_next != 2'd0));
        total_next = total_sat;
        if (char_in.end_of_text) begin
            total_next = '0;
        end
    end

    // Build the result slots: data bytes first, then the summary on the last character.
    always_comb
    begin
        n_res = NRES_W'(n_bytes) + NRES_W'(char_in.end_of_text);
        for (int k = 0; k < MAX_RESULTS; k++) begin
            slot[k].item_kind = KIND_DATA;
            slot[k].data_byte = 8'd0;
            slot[k].decoded_count = '0;
            slot[k].status = STATUS_OK;
            slot[k].last_of_run = (NRES_W'(k) == n_res - NRES_W'(1));
            if (NRES_W'(k) < NRES_W'(n_bytes)) begin
                slot[k].data_byte = bytes[k % 3];
            end else begin
                slot[k].item_kind = KIND_SUMMARY;
                slot[k].status = bad ? STATUS_FAIL : STATUS_OK;
                slot[k].decoded_count = bad ? '0 : DCOUNT_W'(total_sat);
            end
        end
    end

    // Queue pointers and fill level.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (accept) begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(n_res);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + (accept ? FCNT_W'(n_res) : FCNT_W'(0))
                     - (pop ? FCNT_W'(1) : FCNT_W'(0));
    end

    // Control and decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            group_reg <= '0;
            pending_reg <= 2'd0;
            stopped_reg <= 1'b0;
            failed_reg <= 1'b0;
            total_reg <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (accept) begin
                if (char_in.end_of_text) begin
                    group_reg <= '0;
                    pending_reg <= 2'd0;
                    stopped_reg <= 1'b0;
                    failed_reg <= 1'b0;
                end else begin
                    group_reg <= group_next;
                    pending_reg <= pending_next;
                    stopped_reg <= stopped_next;
                    failed_reg <= failed_next;
                end
                total_reg <= total_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Queue payload storage.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                if (NRES_W'(k) < n_res) begin
                    fifo_reg[wr_ptr_reg + PTR_W'(k)] <= slot[k];
                end
            end
        end
    end

    // Head of the queue drives the output channel.
    assign res_out.valid = (count_reg != '0);
    assign res_out.item_kind = fifo_reg[rd_ptr_reg].item_kind;
    assign res_out.data_byte = fifo_reg[rd_ptr_reg].data_byte;
    assign res_out.decoded_count = fifo_reg[rd_ptr_reg].decoded_count;
    assign res_out.status = fifo_reg[rd_ptr_reg].status;
    assign res_out.last_of_run = fifo_reg[rd_ptr_reg].last_of_run;

endmodule

### design/b64d_checker.sv
// Port-level checks for the base64 text decoder and their binding.
`include "base64_text_decoder_core_defines.svh"

module b64d_checker
    import b64d_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input logic                item_kind,
    input logic [7:0]          data_byte,
    input logic [DCOUNT_W-1:0] decoded_count,
    input logic                status,
    input logic                last_of_run
);

    logic [DCOUNT_W+10:0] res_payload;
    logic                 res_data;
    logic                 res_summary;
    logic                 res_failed;

    // Result contents and kinds of the offered item.
    assign res_payload = {item_kind, data_byte, decoded_count, status, last_of_run};
    assign res_data = res_valid && (item_kind == KIND_DATA);
    assign res_summary = res_valid && (item_kind == KIND_SUMMARY);
    assign res_failed = res_summary && (status == STATUS_FAIL);

    // A stalled result holds its contents.
    `B64D_CHK_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_payload))

    // The summary always closes the run of its character.
    `B64D_CHK_IMPLY(a_summary_last, clk, rst_n, res_summary, last_of_run)

    // Data bytes carry no count and no status.
    `B64D_CHK_IMPLY(a_data_clean, clk, rst_n, res_data, (decoded_count == '0) && (status == STATUS_OK))

    // A failed string reports zero bytes and no data.
    `B64D_CHK_IMPLY(a_fail_zero, clk, rst_n, res_failed, (decoded_count == '0) && (data_byte == 8'd0))

endmodule

bind base64_text_decoder_core b64d_checker u_b64d_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_out.valid),
    .res_ready     (res_out.ready),
    .item_kind     (res_out.item_kind),
    .data_byte     (res_out.data_byte),
    .decoded_count (res_out.decoded_count),
    .status        (res_out.status),
    .last_of_run   (res_out.last_of_run)
);

### bench/base64_text_decoder_core_tb.sv
// Self-checking testbench for the streaming base64 text decoder core.
module base64_text_decoder_core_tb
    import b64d_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF = 6;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 400;
    localparam int QUIET_TAIL = 60;
    localparam int HOLD_START = 60;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // One text character waiting to be sent; quiet characters get no idling.
    typedef struct packed {
        logic [7:0] code;
        logic       eot;
        logic       quiet;
    } text_char_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Driven copies of the block inputs, known from time zero.
    logic       in_valid = 1'b0;
    logic [7:0] in_code = '0;
    logic       in_eot = 1'b0;
    logic       out_ready = 1'b0;

    b64d_char_if char_bus ();
    b64d_res_if  res_bus ();

    assign char_bus.valid = in_valid;
    assign char_bus.char_code = in_code;
    assign char_bus.end_of_text = in_eot;
    assign res_bus.ready = out_ready;

    base64_text_decoder_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_bus),
        .res_out (res_bus)
    );

    text_char_t  char_items[$];
    logic [7:0]  text_buf[$];
    result_t     expected_results[$];
    logic [6:0]  sextet_table [256];

    // Decoder state mirrored by the predictor.
    logic [23:0]           acc_bits = '0;
    logic [1:0]            held_sextets = '0;
    logic                  pad_seen = 1'b0;
    logic                  pad_failed = 1'b0;
    logic [COUNT_BITS-1:0] bytes_out = '0;

    int unsigned chars_total = 0;
    int unsigned chars_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int          send_gap = 0;
    int          recv_stall = 0;
    logic        calm = 1'b0;
    logic        hold_res = 1'b0;

    // Clock generation.
    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t ns: %s mismatch at result %0d: got 0x%0h, expected 0x%0h",
                 $time, what, results_seen, got, want);
        mismatches++;
    endtask

    // A data byte result; the string's byte count saturates at its top value.
    function automatic result_t byte_result(input logic [7:0] b);
        result_t r;
        r = '0;
        r.item_kind = KIND_DATA;
        r.data_byte = b;
        if (bytes_out != '1)
        begin
            bytes_out = bytes_out + 1'b1;
        end
        return r;
    endfunction

    // Works out the results of one accepted character and queues them.
    function automatic void predict_char(input logic [7:0] ch, input logic eot);
        result_t    outs [MAX_RESULTS];
        int         n;
        logic [6:0] v;
        logic       bad;
        n = 0;
        if (!pad_seen)
        begin
            if (ch == PAD_CHAR)
            begin
                // Padding flushes the partial group; a lone held character fails the string.
                pad_seen = 1'b1;
                case (held_sextets)
                    2'd1: pad_failed = 1'b1;
                    2'd2:
                    begin
                        outs[0] = byte_result(acc_bits[23:16]);
                        n = 1;
                    end
                    2'd3:
                    begin
                        outs[0] = byte_result(acc_bits[23:16]);
                        outs[1] = byte_result(acc_bits[15:8]);
                        n = 2;
                    end
                    default: ;
                endcase
                acc_bits = '0;
                held_sextets = '0;
            end
            else
            begin
                v = sextet_table[ch];
                if (!v[6])
                begin
                    acc_bits = acc_bits | (24'(v[5:0]) << (18 - 6 * int'(held_sextets)));
                    if (held_sextets == 2'd3)
                    begin
                        outs[0] = byte_result(acc_bits[23:16]);
                        outs[1] = byte_result(acc_bits[15:8]);
                        outs[2] = byte_result(acc_bits[7:0]);
                        n = 3;
                        acc_bits = '0;
                        held_sextets = '0;
                    end
                    else
                    begin
                        held_sextets = held_sextets + 2'd1;
                    end
                end
            end
        end

        // The summary follows the character's own bytes and clears the state.
        if (eot)
        begin
            bad = pad_failed | (!pad_seen && held_sextets != 2'd0);
            outs[n] = '0;
            outs[n].item_kind = KIND_SUMMARY;
            outs[n].status = bad ? STATUS_FAIL : STATUS_OK;
            outs[n].decoded_count = bad ? '0 : DCOUNT_W'(bytes_out);
            n++;
            acc_bits = '0;
            held_sextets = '0;
            pad_seen = 1'b0;
            pad_failed = 1'b0;
            bytes_out = '0;
        end

        if (n > 0)
        begin
            outs[n - 1].last_of_run = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            expected_results.push_back(outs[i]);
        end
    endfunction

    // A random byte that is neither in the alphabet nor padding.
    function automatic logic [7:0] foreign_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (!sextet_table[c][6] || c == PAD_CHAR);
        return c;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            text_buf.push_back(8'(s[i]));
        end
    endtask

    // Encodes n random bytes, optionally padded, with foreign bytes mixed in.
    task automatic encode_bytes(input int n, input bit pad, input int noise_pct);
        logic [23:0] grp;
        int          left;
        int          chars;
        left = n;
        while (left > 0)
        begin
            grp = 24'($urandom);
            chars = (left >= 3) ? 4 : left + 1;
            for (int k = 0; k < chars; k++)
            begin
                if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct)
                begin
                    text_buf.push_back(foreign_char());
                end
                text_buf.push_back(8'(ALPHABET[grp[23 - 6 * k -: 6]]));
            end
            if (pad)
            begin
                repeat (4 - chars) text_buf.push_back(PAD_CHAR);
            end
            left -= 3;
        end
    endtask

    // Moves the built string into the send queue, flagging its last character.
    task automatic commit_text(input bit quiet);
        text_char_t tc;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            tc.code = text_buf[i];
            tc.eot = (i == text_buf.size() - 1);
            tc.quiet = quiet;
            char_items.push_back(tc);
            chars_total++;
        end
        text_buf.delete();
    endtask

    // Mostly well-formed strings, some broken ones, some pure noise.
    task automatic make_random_text();
        int kind;
        int n;
        int cut;
        kind = $urandom_range(0, 99);
        n = $urandom_range(0, 10);
        if (kind < 70)
        begin
            encode_bytes(n, 1'b1, ($urandom_range(0, 3) == 0) ? 15 : 0);
            if (n % 3 == 0 && $urandom_range(0, 1) == 1)
            begin
                text_buf.push_back(PAD_CHAR);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
        else if (kind < 85)
        begin
            // Truncated groups, misplaced or doubled padding.
            encode_bytes(n + 1, 1'b0, 0);
            cut = $urandom_range(1, text_buf.size());
            text_buf = text_buf[0:cut - 1];
            if ($urandom_range(0, 1) == 1)
            begin
                text_buf.insert($urandom_range(0, text_buf.size()), PAD_CHAR);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                text_buf.push_back(PAD_CHAR);
            end
        end
        else
        begin
            repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
        end
        if (text_buf.size() == 0)
        begin
            text_buf.push_back(PAD_CHAR);
        end
    endtask

    // Character driver: records accepted items and presents the next one.
    always @(posedge clk or negedge rst_n)
    begin : char_driver
        text_char_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_code <= '0;
            in_eot <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && char_bus.ready)
            begin
                predict_char(in_code, in_eot);
                chars_accepted++;
            end
            if (!in_valid || char_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (char_items.size() > 0)
                begin
                    nxt = char_items.pop_front();
                    in_valid <= 1'b1;
                    in_code <= nxt.code;
                    in_eot <= nxt.eot;
                    calm <= nxt.quiet;
                    if (!nxt.quiet && !hold_res && $urandom_range(0, 99) < 20)
                    begin
                        send_gap = $urandom_range(1, 10);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted result and paces the ready line.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (out_ready && res_bus.valid)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", res_bus.item_kind, 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_bus.item_kind !== want.item_kind)
                        report_mismatch("item_kind", res_bus.item_kind, want.item_kind);
                    if (res_bus.data_byte !== want.data_byte)
                        report_mismatch("data_byte", res_bus.data_byte, want.data_byte);
                    if (res_bus.decoded_count !== want.decoded_count)
                        report_mismatch("decoded_count", res_bus.decoded_count,
                                        want.decoded_count);
                    if (res_bus.status !== want.status)
                        report_mismatch("status", res_bus.status, want.status);
                    if (res_bus.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", res_bus.last_of_run,
                                        want.last_of_run);
                end
            end
            if (hold_res)
            begin
                out_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 15)
                begin
                    recv_stall = $urandom_range(1, 10);
                end
            end
        end
    end

    // Long receiver hold-off so the result queue fills and input stalls.
    initial
    begin : receiver_hold
        while (chars_accepted < HOLD_START) @(posedge clk);
        hold_res <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_res <= 1'b0;
    end

    // Run limit.
    initial
    begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial
    begin : stimulus
        int unsigned target;
        for (int i = 0; i < 256; i++)
        begin
            sextet_table[i] = 7'h40;
        end
        for (int k = 0; k < 64; k++)
        begin
            sextet_table[8'(ALPHABET[k])] = 7'(k);
        end

        // Directed strings: padding after three, two and one characters,
        // characters after the stop, the alphabet's range edges with a full
        // group completed on the last character, foreign bytes with an
        // unterminated group, and a string that is just padding.
        add_text("TWE=");
        commit_text(1'b0);
        add_text("TQ=A");
        commit_text(1'b0);
        add_text("A=");
        commit_text(1'b0);
        add_text("AZaz09+/");
        commit_text(1'b0);
        text_buf.push_back(8'h00);
        text_buf.push_back(8'hFF);
        add_text("AB");
        text_buf.push_back(8'h7F);
        commit_text(1'b0);
        add_text("=");
        commit_text(1'b0);

        // Random strings; the tail of the run carries no idling.
        target = chars_total + RANDOM_ITEMS;
        while (chars_total < target)
        begin
            make_random_text();
            commit_text(chars_total + QUIET_TAIL > target || $urandom_range(0, 4) == 0);
        end
        make_random_text();
        commit_text(1'b1);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (chars_accepted != chars_total || expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
